// ===== hw/rtl/prc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, register indexes and helpers for the raster crop block.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DIM_W     = 13;  // width/height and box_left/box_bottom
  localparam int unsigned EDGE_W    = 14;  // box_right/box_top
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 14;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [DIM_W-1:0]     dim_t;
  typedef logic [1:0]           pad_t;

  localparam cfg_idx_t REG_PIXEL_FORMAT = 3'd0;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd1;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd2;
  localparam cfg_idx_t REG_BOX_LEFT     = 3'd3;
  localparam cfg_idx_t REG_BOX_RIGHT    = 3'd4;
  localparam cfg_idx_t REG_BOX_BOTTOM   = 3'd5;
  localparam cfg_idx_t REG_BOX_TOP      = 3'd6;

  // Row pad in bytes: w mod 4 for 24-bit pixels, 2 for odd w with 16-bit pixels
  function automatic pad_t row_pad(input logic fmt24, input dim_t w);
    pad_t p;
    if (fmt24) begin
      p = w[1:0];
    end else begin
      p = w[0] ? 2'd2 : 2'd0;
    end
    return p;
  endfunction

  // w * bytes_per_pixel, 16 bits
  function automatic logic [15:0] times_bpp(input logic fmt24, input logic [13:0] w);
    logic [15:0] x2;
    logic [15:0] x1;
    x2 = {1'b0, w, 1'b0};
    x1 = {2'b00, w};
    return fmt24 ? (x2 + x1) : x2;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/padded_raster_crop.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The first result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle unless output stalls or after a config write;
//   a row-ending request holds the output until its N pad bytes (up to 3) are taken.
// A config write holds in_ready_o low for the following cycle.
// Reset: async active low; config to defaults, counters and result register cleared,
//   in_ready_o low for the first cycle after reset.
// ----------------------------------------------------------------------------
// padded_raster_crop
// Crop window over a stored raster byte stream with row pad insertion.
// ----------------------------------------------------------------------------
module padded_raster_crop #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire prc_pkg::cfg_idx_t   cfg_index_i,
  input  wire prc_pkg::cfg_dat_t   cfg_data_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire prc_pkg::byte_t      src_byte_i,
  input  wire                      frame_start_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output prc_pkg::byte_t           out_byte_o,
  output logic                     is_pad_o,
  output logic                     row_end_o,
  output logic                     frame_end_o,
  output logic                     box_empty_o
);
  import prc_pkg::*;

  localparam int unsigned WMAX  = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
  localparam int unsigned HMAX  = (MAX_HEIGHT < 8191) ? MAX_HEIGHT : 8191;
  localparam int unsigned COL_W = $clog2(WMAX * 3 + 4);
  localparam int unsigned ROW_W = $clog2(HMAX);
  localparam int unsigned HQ_W  = ROW_W + 1;

  // config registers
  logic                pixel_format_q;
  dim_t                image_width_q, image_height_q;
  logic [DIM_W-1:0]    box_left_q, box_bottom_q;
  logic [EDGE_W-1:0]   box_right_q, box_top_q;
  logic                cfg_hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= 1'b1;
      image_width_q  <= 13'd1;
      image_height_q <= 13'd1;
      box_left_q     <= '0;
      box_right_q    <= '0;
      box_bottom_q   <= '0;
      box_top_q      <= '0;
      cfg_hold_q     <= 1'b1;
    end else begin
      cfg_hold_q <= cfg_valid_i;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[0];
          REG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[DIM_W-1:0];
          REG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[DIM_W-1:0];
          REG_BOX_LEFT:     box_left_q     <= cfg_data_i[DIM_W-1:0];
          REG_BOX_RIGHT:    box_right_q    <= cfg_data_i[EDGE_W-1:0];
          REG_BOX_BOTTOM:   box_bottom_q   <= cfg_data_i[DIM_W-1:0];
          REG_BOX_TOP:      box_top_q      <= cfg_data_i[EDGE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // derived geometry, registered
  dim_t               w_c, h_c, l13, r13, b13, t13, cw_c;
  logic signed [14:0] l_c, r_c, b_c, t_c, r_s, t_s, wm1, hm1;
  logic [15:0]        first_full, last_full, src_full;

  always_comb begin
    if (image_width_q == '0) begin
      w_c = 13'd1;
    end else if (int'(image_width_q) > MAX_WIDTH) begin
      w_c = DIM_W'(MAX_WIDTH);
    end else begin
      w_c = image_width_q;
    end
    if (image_height_q == '0) begin
      h_c = 13'd1;
    end else if (int'(image_height_q) > MAX_HEIGHT) begin
      h_c = DIM_W'(MAX_HEIGHT);
    end else begin
      h_c = image_height_q;
    end
    wm1 = $signed({2'b00, w_c - 13'd1});
    hm1 = $signed({2'b00, h_c - 13'd1});
    l_c = box_left_q[DIM_W-1]   ? '0 : $signed({2'b00, box_left_q});
    b_c = box_bottom_q[DIM_W-1] ? '0 : $signed({2'b00, box_bottom_q});
    r_s = $signed({box_right_q[EDGE_W-1], box_right_q});
    t_s = $signed({box_top_q[EDGE_W-1], box_top_q});
    r_c = (r_s > wm1) ? wm1 : r_s;
    t_c = (t_s > hm1) ? hm1 : t_s;
    l13 = l_c[DIM_W-1:0];
    r13 = r_c[DIM_W-1:0];
    b13 = b_c[DIM_W-1:0];
    t13 = t_c[DIM_W-1:0];
    cw_c       = r13 - l13 + 13'd1;
    first_full = times_bpp(pixel_format_q, {1'b0, l13});
    last_full  = times_bpp(pixel_format_q, {1'b0, r13} + 14'd1) - 16'd1;
    src_full   = times_bpp(pixel_format_q, {1'b0, w_c})
               + {14'd0, row_pad(pixel_format_q, w_c)};
  end

  logic             empty_q;
  logic [COL_W-1:0] first_q, last_q, src_len_q;
  logic [ROW_W-1:0] bot_q, top_q;
  logic [HQ_W-1:0]  h_q;
  pad_t             tpad_q;

  always_ff @(posedge clk_i) begin
    empty_q   <= (l_c > r_c) || (b_c > t_c);
    first_q   <= COL_W'(first_full);
    last_q    <= COL_W'(last_full);
    src_len_q <= COL_W'(src_full);
    bot_q     <= ROW_W'(b13);
    top_q     <= ROW_W'(t13);
    h_q       <= HQ_W'(h_c);
    tpad_q    <= row_pad(pixel_format_q, cw_c);
  end

  // counters and request evaluation
  logic [COL_W-1:0] col_q, col_cur, col_d;
  logic [ROW_W-1:0] row_q, row_cur, row_d;
  logic [COL_W:0]   col_inc;
  logic [HQ_W-1:0]  row_inc;
  logic             in_fire, at_end, keep, emits;

  logic             ob_valid_q, ob_rend_q, ob_fend_q, ob_empty_q;
  byte_t            ob_byte_q;
  pad_t             ob_npad_q, ob_idx_q;
  logic             ob_last, out_fire;

  assign ob_last    = (ob_idx_q == ob_npad_q);
  assign out_fire   = ob_valid_q && out_ready_i;
  assign in_ready_o = !cfg_hold_q && (!ob_valid_q || (out_ready_i && ob_last));
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    at_end  = (col_cur == last_q);
    keep    = !empty_q && (row_cur >= bot_q) && (row_cur <= top_q)
              && (col_cur >= first_q) && (col_cur <= last_q);
    emits   = empty_q || keep;
    col_inc = {1'b0, col_cur} + 1'b1;
    row_inc = {1'b0, row_cur} + 1'b1;
    col_d   = col_inc[COL_W-1:0];
    row_d   = row_cur;
    if (col_inc >= {1'b0, src_len_q}) begin
      col_d = '0;
      row_d = (row_inc >= h_q) ? '0 : row_inc[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      ob_valid_q <= 1'b0;
      ob_idx_q   <= '0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_fire && emits) begin
        ob_valid_q <= 1'b1;
        ob_idx_q   <= '0;
      end else if (out_fire) begin
        if (ob_last) begin
          ob_valid_q <= 1'b0;
        end else begin
          ob_idx_q <= ob_idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emits) begin
      ob_byte_q  <= empty_q ? '0 : src_byte_i;
      ob_empty_q <= empty_q;
      ob_rend_q  <= !empty_q && at_end;
      ob_fend_q  <= !empty_q && at_end && (row_cur == top_q);
      ob_npad_q  <= (!empty_q && at_end) ? tpad_q : 2'd0;
    end
  end

  // result drive
  always_comb begin
    out_valid_o = ob_valid_q;
    if (ob_idx_q == '0) begin
      out_byte_o  = ob_byte_q;
      is_pad_o    = 1'b0;
      row_end_o   = ob_last && ob_rend_q;
      frame_end_o = ob_last && ob_fend_q;
      box_empty_o = ob_empty_q;
    end else begin
      out_byte_o  = '0;
      is_pad_o    = 1'b1;
      row_end_o   = ob_last;
      frame_end_o = ob_last && ob_fend_q;
      box_empty_o = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== test/padded_raster_crop_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_raster_crop_test
// Streams stored raster bytes through the crop block under several crop
// settings and idle patterns. A local model tracks the byte column and row,
// predicts every kept byte, inserted pad byte and empty-box marker, and each
// output request is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module padded_raster_crop_test;
  import prc_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam cfg_idx_t REG_UNUSED = 3'd7;

  typedef struct packed {
    byte_t data;
    logic  start;
  } raster_in_t;

  typedef struct packed {
    byte_t data;
    logic  pad;
    logic  rend;
    logic  fend;
    logic  empty;
  } crop_byte_t;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     cfg_valid   = 1'b0;
  cfg_idx_t cfg_index   = '0;
  cfg_dat_t cfg_data    = '0;
  logic     in_valid    = 1'b0;
  byte_t    src_byte    = '0;
  logic     frame_start = 1'b0;
  logic     out_ready   = 1'b0;

  logic  cfg_ready;
  logic  in_ready;
  logic  out_valid;
  byte_t out_byte;
  logic  is_pad;
  logic  row_end;
  logic  frame_end;
  logic  box_empty;

  // shadow registers
  logic        fmt_sh    = 1'b1;
  logic [12:0] width_sh  = 13'd1;
  logic [12:0] height_sh = 13'd1;
  logic [12:0] left_sh   = '0;
  logic [13:0] right_sh  = '0;
  logic [12:0] bottom_sh = '0;
  logic [13:0] top_sh    = '0;

  int col = 0;
  int row = 0;

  raster_in_t raster_q[$];
  crop_byte_t cropped_q[$];
  raster_in_t next_in;
  crop_byte_t want;
  int items_left    = 0;
  int errors        = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mode_sel      = 0;

  padded_raster_crop #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .src_byte_i   (src_byte),
    .frame_start_i(frame_start),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_o   (out_byte),
    .is_pad_o     (is_pad),
    .row_end_o    (row_end),
    .frame_end_o  (frame_end),
    .box_empty_o  (box_empty)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int crop_pad(input logic fmt24, input int w);
    if (fmt24) begin
      return w % 4;
    end
    return (w % 2 == 1) ? 2 : 0;
  endfunction

  function automatic int fit_size(input logic [12:0] v, input int hi);
    if (v == 0) begin
      return 1;
    end
    if (int'(v) > hi) begin
      return hi;
    end
    return int'(v);
  endfunction

  function automatic int raster_len();
    int w;
    w = fit_size(width_sh, MAX_W);
    return (w * (fmt_sh ? 3 : 2) + crop_pad(fmt_sh, w)) * fit_size(height_sh, MAX_H);
  endfunction

  task automatic push_result(input byte_t b, input logic pad, input logic rend,
                             input logic fend, input logic empty);
    cropped_q.push_back('{data: b, pad: pad, rend: rend, fend: fend, empty: empty});
  endtask

  task automatic crop_step(input byte_t b, input logic fs);
    int bpp, w, h, src_len, l, r, bot, top, first, last, tpad;
    logic fend;
    bpp = fmt_sh ? 3 : 2;
    w = fit_size(width_sh, MAX_W);
    h = fit_size(height_sh, MAX_H);
    src_len = w * bpp + crop_pad(fmt_sh, w);
    if (fs) begin
      col = 0;
      row = 0;
    end
    l   = $signed(left_sh);
    r   = $signed(right_sh);
    bot = $signed(bottom_sh);
    top = $signed(top_sh);
    if (l < 0) l = 0;
    if (r > w - 1) r = w - 1;
    if (bot < 0) bot = 0;
    if (top > h - 1) top = h - 1;
    if (l > r || bot > top) begin
      push_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
    end else begin
      first = l * bpp;
      last  = (r + 1) * bpp - 1;
      if (row >= bot && row <= top && col >= first && col <= last) begin
        tpad = (col == last) ? crop_pad(fmt_sh, r - l + 1) : 0;
        fend = (col == last) && (row == top);
        if (tpad == 0) begin
          push_result(b, 1'b0, col == last, fend, 1'b0);
        end else begin
          push_result(b, 1'b0, 1'b0, 1'b0, 1'b0);
          for (int i = 1; i <= tpad; i++) begin
            push_result('0, 1'b1, i == tpad, (i == tpad) && fend, 1'b0);
          end
        end
      end
    end
    col++;
    if (col >= src_len) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        crop_step(src_byte, frame_start);
        items_left--;
      end
      if (!in_valid || in_ready) begin
        if (raster_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_in = raster_q.pop_front();
          src_byte    <= next_in.data;
          frame_start <= next_in.start;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (cropped_q.size() == 0) begin
        $error("unexpected request: out_byte %0h is_pad %0b box_empty %0b",
               out_byte, is_pad, box_empty);
        errors++;
      end else begin
        want = cropped_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          errors++;
        end
        if (is_pad !== want.pad) begin
          $error("is_pad: expected %0b, got %0b", want.pad, is_pad);
          errors++;
        end
        if (row_end !== want.rend) begin
          $error("row_end: expected %0b, got %0b", want.rend, row_end);
          errors++;
        end
        if (frame_end !== want.fend) begin
          $error("frame_end: expected %0b, got %0b", want.fend, frame_end);
          errors++;
        end
        if (box_empty !== want.empty) begin
          $error("box_empty: expected %0b, got %0b", want.empty, box_empty);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // leaves cfg_valid high; caller drops it after the last write
  task automatic write_reg(input cfg_idx_t idx, input cfg_dat_t dat);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIXEL_FORMAT: fmt_sh    = dat[0];
      REG_IMAGE_WIDTH:  width_sh  = dat[12:0];
      REG_IMAGE_HEIGHT: height_sh = dat[12:0];
      REG_BOX_LEFT:     left_sh   = dat[12:0];
      REG_BOX_RIGHT:    right_sh  = dat;
      REG_BOX_BOTTOM:   bottom_sh = dat[12:0];
      REG_BOX_TOP:      top_sh    = dat;
      default: ;
    endcase
  endtask

  task automatic configure(input int fmt, input int w, input int h, input int l,
                           input int r, input int bot, input int top);
    write_reg(REG_PIXEL_FORMAT, cfg_dat_t'(fmt));
    write_reg(REG_IMAGE_WIDTH, cfg_dat_t'(w));
    write_reg(REG_IMAGE_HEIGHT, cfg_dat_t'(h));
    write_reg(REG_BOX_LEFT, cfg_dat_t'(l));
    write_reg(REG_BOX_RIGHT, cfg_dat_t'(r));
    write_reg(REG_BOX_BOTTOM, cfg_dat_t'(bot));
    write_reg(REG_BOX_TOP, cfg_dat_t'(top));
    write_reg(REG_UNUSED, cfg_dat_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic small_config();
    int w, h, l, bot;
    w   = $urandom_range(1, 6);
    h   = $urandom_range(1, 3);
    l   = int'($urandom_range(w + 2)) - 2;
    bot = int'($urandom_range(h + 1)) - 1;
    configure($urandom_range(1), w, h, l, l - 1 + int'($urandom_range(w + 2)),
              bot, bot - 1 + int'($urandom_range(h + 1)));
  endtask

  task automatic wild_config();
    for (int i = 0; i < 8; i++) begin
      write_reg(cfg_idx_t'(i), cfg_dat_t'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic push_item(input byte_t b, input logic fs);
    raster_q.push_back('{data: b, start: fs});
    items_left++;
  endtask

  task automatic push_frame(input int n, input logic with_start);
    for (int i = 0; i < n; i++) begin
      push_item(byte_t'($urandom), with_start && i == 0);
    end
  endtask

  task automatic next_mode();
    case (mode_sel)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
    mode_sel = (mode_sel + 1) % 4;
  endtask

  task automatic drain();
    do @(posedge clk); while (items_left != 0 || cropped_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int flen, sent, pick, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: one 24-bit pixel, source pad byte last
    next_mode();
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'hA5, 1'b0);
    push_item(8'h5A, 1'b0);
    drain();

    // 16-bit, odd width, box far outside on every side
    next_mode();
    configure(0, 1, 2, -4096, 8191, -4096, 8191);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item(8'hFE, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(8'h3C, 1'b0);
    drain();

    // zero width, oversized height, left past right
    next_mode();
    configure(1, 0, 8191, 4095, -4096, 0, 0);
    push_item(8'h12, 1'b1);
    push_item(8'h34, 1'b0);
    push_item(8'h56, 1'b0);
    drain();

    // oversized width, two-pixel box with two pad bytes
    next_mode();
    configure(1, 8191, 1, 0, 1, -1, 0);
    push_frame(7, 1'b1);
    drain();

    // bottom past top; column left beyond the new row length
    next_mode();
    configure(0, 2, 4, 0, 3, 3, 2);
    push_item(8'hC3, 1'b0);
    push_item(8'h3C, 1'b0);
    drain();

    repeat (4) begin
      next_mode();
      if ($urandom_range(4) == 0) begin
        wild_config();
      end else begin
        small_config();
      end
      flen = raster_len();
      sent = 0;
      while (sent < 12) begin
        pick = $urandom_range(9);
        if (flen > 64 || pick >= 8) begin
          n = $urandom_range(1, 4);
          repeat (n) push_item(byte_t'($urandom), $urandom_range(3) == 0);
        end else begin
          n = (pick == 7 && flen > 1) ? $urandom_range(1, flen - 1) : flen;
          push_frame(n, pick != 6);
        end
        sent += n;
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
